### src/swdas_pkg.sv
// Shared types and constants for the sensor window block (daylight and humidity swing).
// No dependencies; swdas_queue, swdas_back and the top level import this package.
`default_nettype none

package swdas_pkg;

  // Window size default and field widths
  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int LIGHT_W          = 10;
  localparam int HUM_W            = 14;
  localparam int THR_W            = 10;
  localparam int CNT_W            = 4;
  localparam int SUM_W            = 13;   // eight light samples of 10 bits
  localparam int PROD_W           = THR_W + CNT_W;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 16;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int QUEUE_DEPTH      = 2;

  // Reset values of the history and the registers
  localparam logic [LIGHT_W-1:0] LIGHT_RESET  = 10'd1000;
  localparam logic [THR_W-1:0]   THRESH_RESET = 10'd800;
  localparam logic [CNT_W-1:0]   COUNT_RESET  = 4'd3;
  localparam logic [CNT_W-1:0]   COUNT_MAX    = 4'd8;

  // One sample as packed on the input stream, light in the low bits
  typedef struct packed {
    logic [HUM_W-1:0]   hum;
    logic [LIGHT_W-1:0] light;
  } sample_t;

  // One result as packed on the output stream, daylight in the low bit
  typedef struct packed {
    logic             still_filling;
    logic [HUM_W-1:0] humidity_swing;
    logic             daylight;
  } result_t;

  // Status of the back end seen by the top level
  typedef struct packed {
    logic busy;
    logic window_full;
  } back_stat_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_SCAN,
    BK_TAIL,
    BK_RESULT
  } back_state_t;

  // Configuration register indexes (word address bit 2)
  typedef enum logic {
    REG_THRESH = 1'b0,
    REG_AVG    = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

### src/swdas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the light and humidity histories.
`default_nettype none

module swdas_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  // Write one entry, register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### src/swdas_queue.sv
// Front end: accepts sample requests into a short queue ahead of the back end.
// Depends on swdas_pkg.
`default_nettype none

module swdas_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swdas_pkg::sample_t in_smp,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output swdas_pkg::sample_t     q_smp
);
  import swdas_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sample_t        ent_r [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_smp    = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the payload of each queued request
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_smp;
    end
  end

endmodule

`default_nettype wire

### src/swdas_back.sv
// Back end: stores a sample, scans the window memories, builds one result.
// Depends on swdas_pkg and swdas_ram.
`default_nettype none

module swdas_back #(
  parameter int WINDOW_DEPTH = swdas_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         smp_valid,
  output logic                              smp_ready,
  input  wire swdas_pkg::sample_t           smp,
  input  wire logic [swdas_pkg::THR_W-1:0]  day_threshold,
  input  wire logic [swdas_pkg::CNT_W-1:0]  avg_count,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output swdas_pkg::result_t                res,
  output swdas_pkg::back_stat_t             stat
);
  import swdas_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  back_state_t        state_r, state_nxt;
  sample_t            cur_r;
  logic [AW-1:0]      ws_r;
  logic [FW-1:0]      fill_r;
  logic [AW-1:0]      cnt_r;
  logic [AW-1:0]      lptr_r;
  logic [CNT_W-1:0]   lrem_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   n_clamp;
  logic               rd_vld_r;
  logic               rd_light_r;
  logic [AW-1:0]      rd_idx_r;
  logic [AW-1:0]      rd_lidx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [HUM_W-1:0]   hmin_r;
  logic [HUM_W-1:0]   hmax_r;
  logic               out_vld_r;
  result_t            res_r;

  logic               take;
  logic               ram_we;
  logic               scan_en;
  logic               load_res;
  logic [LIGHT_W-1:0] light_rd;
  logic [HUM_W-1:0]   hum_rd;
  logic [LIGHT_W-1:0] light_val;
  logic [HUM_W-1:0]   hum_val;
  logic [PROD_W-1:0]  thr_prod;
  result_t            res_nxt;

  // Window memories
  swdas_ram #(.W(LIGHT_W), .DEPTH(WINDOW_DEPTH)) u_light_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ws_r),
    .wdata (cur_r.light),
    .raddr (lptr_r),
    .rdata (light_rd)
  );

  swdas_ram #(.W(HUM_W), .DEPTH(WINDOW_DEPTH)) u_hum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ws_r),
    .wdata (cur_r.hum),
    .raddr (cnt_r),
    .rdata (hum_rd)
  );

  // Clamp the averaging count to 1..8
  always_comb begin
    if (avg_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (avg_count > COUNT_MAX) begin
      n_clamp = COUNT_MAX;
    end else begin
      n_clamp = avg_count;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (smp_valid) state_nxt = BK_WRITE;
      BK_WRITE:  state_nxt = BK_SCAN;
      BK_SCAN:   if (cnt_r == AW'(WINDOW_DEPTH - 1)) state_nxt = BK_TAIL;
      BK_TAIL:   state_nxt = BK_RESULT;
      BK_RESULT: if (!out_vld_r || res_ready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // State decoded controls
  always_comb begin
    smp_ready = 1'b0;
    ram_we    = 1'b0;
    scan_en   = 1'b0;
    load_res  = 1'b0;
    unique case (state_r)
      BK_IDLE:   smp_ready = 1'b1;
      BK_WRITE:  ram_we    = 1'b1;
      BK_SCAN:   scan_en   = 1'b1;
      BK_TAIL:   ;
      BK_RESULT: load_res  = !out_vld_r || res_ready;
      default:   ;
    endcase
  end

  assign take = smp_valid && smp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance write slot and saturating fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      fill_r <= '0;
    end else if (ram_we) begin
      ws_r <= (ws_r == AW'(WINDOW_DEPTH - 1)) ? '0 : ws_r + 1'b1;
      if (fill_r != FW'(WINDOW_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Hold the request and its averaging count
  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= smp;
      n_r   <= n_clamp;
    end
  end

  // Scan counters: humidity over every slot, light back from the newest
  always_ff @(posedge clk) begin
    if (ram_we) begin
      cnt_r  <= '0;
      lptr_r <= ws_r;
      lrem_r <= n_r;
    end else if (scan_en) begin
      cnt_r <= cnt_r + 1'b1;
      if (lrem_r != '0) begin
        lrem_r <= lrem_r - 1'b1;
        lptr_r <= (lptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : lptr_r - 1'b1;
      end
    end
  end

  // Tag the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= cnt_r;
    rd_lidx_r  <= lptr_r;
    rd_light_r <= scan_en && (lrem_r != '0);
  end

  // Slots not yet written read as their reset values
  assign light_val = ({{(FW-AW){1'b0}}, rd_lidx_r} < fill_r) ? light_rd : LIGHT_RESET;
  assign hum_val   = ({{(FW-AW){1'b0}}, rd_idx_r} < fill_r) ? hum_rd : '0;

  // Accumulate light sum and humidity extremes
  always_ff @(posedge clk) begin
    if (ram_we) begin
      sum_r <= '0;
    end else if (rd_vld_r) begin
      if (rd_light_r) begin
        sum_r <= sum_r + SUM_W'(light_val);
      end
      if (rd_idx_r == '0) begin
        hmin_r <= hum_val;
        hmax_r <= hum_val;
      end else begin
        if (hum_val < hmin_r) hmin_r <= hum_val;
        if (hum_val > hmax_r) hmax_r <= hum_val;
      end
    end
  end

  // Build the result
  assign thr_prod               = PROD_W'(day_threshold) * PROD_W'(n_r);
  assign res_nxt.daylight       = (PROD_W'(sum_r) > thr_prod);
  assign res_nxt.humidity_swing = hmax_r - hmin_r;
  assign res_nxt.still_filling  = (fill_r != FW'(WINDOW_DEPTH));

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_res) begin
      out_vld_r <= 1'b1;
    end else if (res_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid        = out_vld_r;
  assign res              = res_r;
  assign stat.busy        = (state_r != BK_IDLE);
  assign stat.window_full = (fill_r == FW'(WINDOW_DEPTH));

endmodule

`default_nettype wire

### src/sensor_window_day_and_swing.sv
// Sensor window top level: daylight from the newest light samples, humidity swing.
// Samples are handled one at a time: the scan of the humidity memory through its single read
// port must finish before the next sample is taken; a two-entry queue accepts up to two
// requests meanwhile.
// Reset (rst_n, synchronous): registers to 800 and 3, queue and output empty; the
// memories are not swept, a fill count marks unwritten slots as their reset values.
`default_nettype none

module sensor_window_day_and_swing #(
  parameter int WINDOW_DEPTH = swdas_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // tdata: light_level[9:0], abs_humidity[23:10]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [swdas_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tdata: daylight[0], humidity_swing[14:1], still_filling[15]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [swdas_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [swdas_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [swdas_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [swdas_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                    cfg_pready
);
  import swdas_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] avg_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  logic             q_valid;
  logic             q_ready;
  sample_t          q_smp;
  result_t          res;
  back_stat_t       stat;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
      avg_r <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_THRESH: thr_r <= cfg_pwdata[THR_W-1:0];
        REG_AVG:    avg_r <= cfg_pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (cfg_sel)
      REG_THRESH: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_AVG:    cfg_prdata = CFG_DATA_W'(avg_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Front: queue the sample requests
  swdas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_smp   (sample_t'(in_tdata)),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_smp    (q_smp)
  );

  // Back: store, scan and report
  swdas_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .smp_valid     (q_valid),
    .smp_ready     (q_ready),
    .smp           (q_smp),
    .day_threshold (thr_r),
    .avg_count     (avg_r),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res),
    .stat          (stat)
  );

  assign out_tdata = OUT_TDATA_W'(res);

  // A queued request taken by the back end makes it busy next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> stat.busy)
    else $error("back end did not start on a taken request");

  // A result that says the window is full needs a full fill count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[15]) |-> stat.window_full)
    else $error("window reported full before fill count saturated");

  // Reset drops any pending result
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
